@@ src/heater_pi_with_antiwindup_macros.svh @@
// ----------------------------------------------------------------------------
// heater pi controller assertion macros
// concurrent assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef HEATER_PI_WITH_ANTIWINDUP_MACROS_SVH
`define HEATER_PI_WITH_ANTIWINDUP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define HPI_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define HPI_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HPI_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons, msg)
`define HPI_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg)
`endif

`endif

@@ src/hpi_pkg.sv @@
// ----------------------------------------------------------------------------
// hpi_pkg
// shared types and constants of the heater pi controller
// ----------------------------------------------------------------------------
package hpi_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SET_POINT = 2'd0,
    REG_ROOM_TEMP = 2'd1,
    REG_PROP_GAIN = 2'd2,
    REG_LOAD_GAIN = 2'd3
  } reg_idx_t;

  localparam int TEMP_W    = 14;
  localparam int GAIN_W    = 8;
  localparam int RAW_W     = 16;
  localparam int DELTA_W   = 15;
  localparam int DRIVE_W   = 17;
  localparam int INTEG_W   = 16;
  localparam int MISS_W    = 3;
  localparam int DUTY_W    = 8;
  localparam int LEVEL_W   = 4;
  localparam int CFG_W     = 14;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [TEMP_W-1:0] SET_POINT_RST    = 14'd3000;
  localparam logic [TEMP_W-1:0] ROOM_TEMP_RST    = 14'd1900;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST    = 8'd58;
  localparam logic [GAIN_W-1:0] LOAD_GAIN_RST    = 8'd4;
  localparam logic [TEMP_W-1:0] CURRENT_TEMP_RST = 14'd2000;
  localparam logic [18:0]       READING_MAX      = 19'd12500;
  localparam logic [MISS_W-1:0] MISS_SAT         = 3'd7;
  localparam logic [DUTY_W-1:0] DUTY_FULL        = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL      = 4'd9;

  // classified reading handed from front to back
  typedef struct packed {
    logic                ok;
    logic [TEMP_W-1:0]   temp;
    logic [DELTA_W-1:0]  delta;
    logic [DRIVE_W-1:0]  drive;
  } work_t;

  // configuration seen by the front
  typedef struct packed {
    logic [TEMP_W-1:0] set_point;
    logic [TEMP_W-1:0] room_temp;
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] load_gain;
  } cfg_t;

  function automatic logic [LEVEL_W-1:0] level_of(input logic [DUTY_W-1:0] d);
    logic [DUTY_W:0] s;
    s = {1'b0, d} + 9'd31;
    if (d == DUTY_FULL) begin
      return LEVEL_FULL;
    end
    return s[DUTY_W:5];
  endfunction

endpackage

@@ src/hpi_front.sv @@
// ----------------------------------------------------------------------------
// hpi_front
// scales the raw reading, range-checks it and forms the proportional plus
// feedforward drive
// ----------------------------------------------------------------------------
module hpi_front (
  input  logic [hpi_pkg::RAW_W-1:0] raw_reading,
  input  hpi_pkg::cfg_t             cfg,
  output hpi_pkg::work_t            item
);

  logic [22:0]                         raw_x100;
  logic [18:0]                         reading;
  logic                                ok;
  logic signed [hpi_pkg::DELTA_W-1:0]  sp_s;
  logic signed [hpi_pkg::DELTA_W-1:0]  temp_s;
  logic signed [hpi_pkg::DELTA_W-1:0]  room_s;
  logic signed [hpi_pkg::DELTA_W-1:0]  delta;
  logic signed [hpi_pkg::DELTA_W-1:0]  load;
  logic signed [23:0]                  p_prod;
  logic signed [23:0]                  l_prod;
  logic signed [24:0]                  sum;
  logic signed [24:0]                  sum_adj;
  logic signed [24:0]                  sum_q;

  // raw * 100 as shift-add, then / 16
  assign raw_x100 = {1'b0, raw_reading, 6'd0} + {2'd0, raw_reading, 5'd0}
                  + {5'd0, raw_reading, 2'd0};
  assign reading  = raw_x100[22:4];
  assign ok       = (reading != 19'd0) && (reading < hpi_pkg::READING_MAX);

  assign sp_s   = {1'b0, cfg.set_point};
  assign temp_s = {1'b0, reading[hpi_pkg::TEMP_W-1:0]};
  assign room_s = {1'b0, cfg.room_temp};
  assign delta  = sp_s - temp_s;
  assign load   = sp_s - room_s;

  assign p_prod = delta * $signed({1'b0, cfg.prop_gain});
  assign l_prod = load * $signed({1'b0, cfg.load_gain});
  assign sum    = 25'(p_prod) + 25'(l_prod);

  // divide by 256 truncating toward zero
  assign sum_adj = sum + (sum < 0 ? 25'sd255 : 25'sd0);
  assign sum_q   = sum_adj >>> 8;

  assign item.ok    = ok;
  assign item.temp  = reading[hpi_pkg::TEMP_W-1:0];
  assign item.delta = delta;
  assign item.drive = sum_q[hpi_pkg::DRIVE_W-1:0];

endmodule

@@ src/hpi_queue.sv @@
// ----------------------------------------------------------------------------
// hpi_queue
// small item queue between front and back
// ----------------------------------------------------------------------------
`include "heater_pi_with_antiwindup_macros.svh"

module hpi_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  hpi_pkg::work_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output hpi_pkg::work_t pop_item
);

  localparam int PTR_W = $clog2(hpi_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(hpi_pkg::QUEUE_DEPTH + 1);

  hpi_pkg::work_t    mem_r [hpi_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push;
  logic              pop;

  assign push_ready = (count_r != CNT_W'(hpi_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(hpi_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(hpi_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `HPI_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(hpi_pkg::QUEUE_DEPTH), "queue count beyond depth")

endmodule

@@ src/hpi_back.sv @@
// ----------------------------------------------------------------------------
// hpi_back
// integrator with conditional integration and rise/fall reset, duty clamp,
// miss counting and fault latch, output register
// ----------------------------------------------------------------------------
`include "heater_pi_with_antiwindup_macros.svh"

module hpi_back #(
  parameter int INTEGRATOR_LIMIT = 16384,
  parameter int MISS_LIMIT       = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  hpi_pkg::work_t                item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hpi_pkg::DUTY_W-1:0]    out_duty,
  output logic [hpi_pkg::LEVEL_W-1:0]   out_power_level,
  output logic [hpi_pkg::TEMP_W-1:0]    out_temperature,
  output logic                          out_reading_ok,
  output logic                          out_fault
);

  logic [hpi_pkg::TEMP_W-1:0]          cur_temp_r, cur_temp_nxt;
  logic [hpi_pkg::TEMP_W-1:0]          prev_temp_r, prev_temp_nxt;
  logic signed [hpi_pkg::INTEG_W-1:0]  integ_r, integ_nxt;
  logic [hpi_pkg::DUTY_W-1:0]          held_duty_r, held_duty_nxt;
  logic [hpi_pkg::MISS_W-1:0]          miss_count_r, miss_count_nxt;
  logic                                fault_latch_r, fault_latch_nxt;

  logic                                out_valid_r;
  logic [hpi_pkg::DUTY_W-1:0]          out_duty_r;
  logic [hpi_pkg::LEVEL_W-1:0]         out_level_r;
  logic [hpi_pkg::TEMP_W-1:0]          out_temp_r;
  logic                                out_ok_r;
  logic                                out_fault_r;

  logic                                fire;
  logic signed [hpi_pkg::DRIVE_W-1:0]  drive;
  logic signed [hpi_pkg::DELTA_W-1:0]  delta;
  logic signed [hpi_pkg::DELTA_W-1:0]  vel;
  logic                                integ_en;
  logic signed [16:0]                  lim_pos;
  logic signed [16:0]                  integ_sum;
  logic signed [16:0]                  integ_cl;
  logic signed [hpi_pkg::INTEG_W-1:0]  integ_upd;
  logic signed [16:0]                  integ_adj;
  logic signed [16:0]                  integ_q;
  logic signed [17:0]                  drive_sum;
  logic [hpi_pkg::DUTY_W-1:0]          duty_cl;
  logic [3:0]                          miss_inc;

  assign item_ready = !out_valid_r || out_ready;
  assign fire       = item_valid && item_ready;

  assign drive   = item.drive;
  assign delta   = item.delta;
  assign vel     = $signed({1'b0, item.temp}) - $signed({1'b0, prev_temp_r});
  assign lim_pos = 17'(INTEGRATOR_LIMIT);

  assign integ_en = (drive < 17'sd255 && drive > 17'sd0)
                 || (drive >= 17'sd255 && delta < 15'sd0)
                 || (drive <= 17'sd0 && delta > 15'sd0);

  assign integ_sum = 17'(integ_r) + 17'(delta);

  always_comb begin
    priority if (!integ_en) begin
      integ_cl = 17'(integ_r);
    end else if (integ_sum > lim_pos) begin
      integ_cl = lim_pos;
    end else if (integ_sum < -lim_pos) begin
      integ_cl = -lim_pos;
    end else begin
      integ_cl = integ_sum;
    end
  end

  // fast rise or fall zeroes a same-sign integrator
  always_comb begin
    priority if (vel > 15'sd4 && integ_cl > 17'sd0) begin
      integ_upd = '0;
    end else if (vel < -15'sd3 && integ_cl < 17'sd0) begin
      integ_upd = '0;
    end else begin
      integ_upd = integ_cl[hpi_pkg::INTEG_W-1:0];
    end
  end

  assign integ_adj = 17'(integ_upd) + (integ_upd < 0 ? 17'sd255 : 17'sd0);
  assign integ_q   = integ_adj >>> 8;
  assign drive_sum = 18'(drive) + 18'(integ_q);

  always_comb begin
    priority if (drive_sum < 18'sd0) begin
      duty_cl = '0;
    end else if (drive_sum > 18'sd255) begin
      duty_cl = hpi_pkg::DUTY_FULL;
    end else begin
      duty_cl = drive_sum[hpi_pkg::DUTY_W-1:0];
    end
  end

  assign miss_inc = {1'b0, miss_count_r} + 4'd1;

  always_comb begin
    cur_temp_nxt    = cur_temp_r;
    prev_temp_nxt   = prev_temp_r;
    integ_nxt       = integ_r;
    held_duty_nxt   = held_duty_r;
    miss_count_nxt  = miss_count_r;
    fault_latch_nxt = fault_latch_r;
    if (fire && !fault_latch_r) begin
      if (item.ok) begin
        cur_temp_nxt   = item.temp;
        prev_temp_nxt  = item.temp;
        integ_nxt      = integ_upd;
        held_duty_nxt  = duty_cl;
        miss_count_nxt = '0;
      end else begin
        if (miss_inc > 4'(MISS_LIMIT)) begin
          fault_latch_nxt = 1'b1;
        end
        miss_count_nxt = (miss_inc > 4'(hpi_pkg::MISS_SAT)) ? hpi_pkg::MISS_SAT
                                                            : miss_inc[hpi_pkg::MISS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_temp_r    <= hpi_pkg::CURRENT_TEMP_RST;
      prev_temp_r   <= '0;
      integ_r       <= '0;
      held_duty_r   <= '0;
      miss_count_r  <= '0;
      fault_latch_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      cur_temp_r    <= cur_temp_nxt;
      prev_temp_r   <= prev_temp_nxt;
      integ_r       <= integ_nxt;
      held_duty_r   <= held_duty_nxt;
      miss_count_r  <= miss_count_nxt;
      fault_latch_r <= fault_latch_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_duty_r  <= fault_latch_nxt ? '0 : held_duty_nxt;
      out_level_r <= fault_latch_nxt ? '0 : hpi_pkg::level_of(held_duty_nxt);
      out_temp_r  <= cur_temp_nxt;
      out_ok_r    <= item.ok;
      out_fault_r <= fault_latch_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_duty        = out_duty_r;
  assign out_power_level = out_level_r;
  assign out_temperature = out_temp_r;
  assign out_reading_ok  = out_ok_r;
  assign out_fault       = out_fault_r;

  `HPI_ASSERT_NEXT(a_fault_sticky, clk, rst_n, fault_latch_r, fault_latch_r, "fault latch cleared without reset")
  `HPI_ASSERT_IMPLY(a_fault_off, clk, rst_n, out_valid_r && out_fault_r, out_duty_r == '0 && out_level_r == '0, "heater driven while faulted")
  `HPI_ASSERT_NEXT(a_miss_clear, clk, rst_n, fire && item.ok && !fault_latch_r, miss_count_r == '0, "miss count kept after good reading")
  `HPI_ASSERT_NEXT(a_integ_bound, clk, rst_n, 1'b1, integ_r <= 16'(INTEGRATOR_LIMIT) && integ_r >= -16'(INTEGRATOR_LIMIT), "integrator beyond limit")

endmodule

@@ src/heater_pi_with_antiwindup.sv @@
// ----------------------------------------------------------------------------
// heater_pi_with_antiwindup
// pi heater controller with set-point feedforward, anti-windup and fault latch
// ----------------------------------------------------------------------------
// One result item per accepted reading. A new reading is taken every clock
// cycle while the queue has room; its result is written into a queue entry
// and then into the output register. The front scales and range-checks the
// reading and forms the proportional plus feedforward drive in the accepting
// cycle; a two-entry queue then feeds the back, whose integrator and fault
// state update takes one item per cycle while the output does not stall. The
// user must write configuration registers through cfg_we/cfg_index/cfg_wdata
// only while no item is in flight; the block itself does not enforce this.
module heater_pi_with_antiwindup #(
  parameter int INTEGRATOR_LIMIT = 16384,
  parameter int MISS_LIMIT       = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [hpi_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hpi_pkg::RAW_W-1:0]     in_raw_reading,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hpi_pkg::DUTY_W-1:0]    out_duty,
  output logic [hpi_pkg::LEVEL_W-1:0]   out_power_level,
  output logic [hpi_pkg::TEMP_W-1:0]    out_temperature,
  output logic                          out_reading_ok,
  output logic                          out_fault
);

  hpi_pkg::cfg_t   cfg_r, cfg_nxt;
  hpi_pkg::work_t  front_item;
  hpi_pkg::work_t  back_item;
  logic            back_valid;
  logic            back_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (hpi_pkg::reg_idx_t'(cfg_index))
        hpi_pkg::REG_SET_POINT: cfg_nxt.set_point = cfg_wdata;
        hpi_pkg::REG_ROOM_TEMP: cfg_nxt.room_temp = cfg_wdata;
        hpi_pkg::REG_PROP_GAIN: cfg_nxt.prop_gain = cfg_wdata[hpi_pkg::GAIN_W-1:0];
        hpi_pkg::REG_LOAD_GAIN: cfg_nxt.load_gain = cfg_wdata[hpi_pkg::GAIN_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_point <= hpi_pkg::SET_POINT_RST;
      cfg_r.room_temp <= hpi_pkg::ROOM_TEMP_RST;
      cfg_r.prop_gain <= hpi_pkg::PROP_GAIN_RST;
      cfg_r.load_gain <= hpi_pkg::LOAD_GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hpi_front u_front (
    .raw_reading (in_raw_reading),
    .cfg         (cfg_r),
    .item        (front_item)
  );

  hpi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_item   (back_item)
  );

  hpi_back #(
    .INTEGRATOR_LIMIT (INTEGRATOR_LIMIT),
    .MISS_LIMIT       (MISS_LIMIT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (back_valid),
    .item_ready      (back_ready),
    .item            (back_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_duty        (out_duty),
    .out_power_level (out_power_level),
    .out_temperature (out_temperature),
    .out_reading_ok  (out_reading_ok),
    .out_fault       (out_fault)
  );

endmodule
